### rtl/core/nc2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nc2d_pkg
// Constants, widths and shared types of the normalized 2D convolution block.
// ----------------------------------------------------------------------------
package nc2d_pkg;

    localparam int MAX_KERNEL = 7;
    localparam int MAX_COLS   = 1024;
    localparam int COEF_BITS  = 16;

    localparam int TAPS      = MAX_KERNEL * MAX_KERNEL;
    localparam int KW        = $clog2(MAX_KERNEL + 1);
    localparam int KCFG_W    = 3;
    localparam int COLW      = $clog2(MAX_COLS);
    localparam int COLS_W    = 11;
    localparam int ROWS_W    = 16;
    localparam int PIX_W     = 24;
    localparam int IDX_W     = 6;
    localparam int COEF_IN_W = 16;
    localparam int TAP_W     = $clog2(TAPS);
    localparam int CNT_W     = TAP_W + 1;
    localparam int SUM_W     = COEF_BITS + TAP_W;
    localparam int PROD_W    = 8 + COEF_BITS;
    localparam int ACC_W     = PROD_W + TAP_W;
    localparam int LS_DEPTH  = (MAX_KERNEL - 1) * MAX_COLS;
    localparam int LS_AW     = $clog2(LS_DEPTH);
    localparam int SLOT_W    = $clog2(MAX_KERNEL);
    localparam int WIN_AW    = SLOT_W + KW;
    localparam int CFG_IW    = 2;
    localparam int CFG_DW    = 16;
    localparam int Q_DEPTH   = 2;

    typedef enum logic [CFG_IW-1:0] {
        CFG_KERNEL = 2'd0,
        CFG_COLS   = 2'd1,
        CFG_ROWS   = 2'd2
    } cfg_idx_t;

    // front to back control
    typedef struct packed {
        logic [KW-1:0] k;
        logic          refresh;
    } ctl_t;

    typedef struct packed {
        logic                              is_coef;
        logic [IDX_W-1:0]                  idx;
        logic [COEF_BITS-1:0]              val;
        logic [MAX_KERNEL-1:0][PIX_W-1:0]  column;
        logic                              emit;
        logic                              last;
    } q_item_t;

endpackage

### rtl/core/nc2d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nc2d_front
// Accepts words, keeps configuration and frame position, reads and ages the
// line store and hands one column or coefficient load per word to the queue.
// ----------------------------------------------------------------------------
module nc2d_front import nc2d_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IW-1:0]     cfg_index,
    input  logic [CFG_DW-1:0]     cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [IDX_W-1:0]      s_coef_index,
    input  logic [COEF_IN_W-1:0]  s_coef_value,
    input  logic [7:0]            s_pixel_ch0,
    input  logic [7:0]            s_pixel_ch1,
    input  logic [7:0]            s_pixel_ch2,
    output ctl_t                  ctl,
    output logic                  q_push,
    output q_item_t               q_item,
    input  logic                  q_full
);

    typedef enum logic [1:0] {F_IDLE, F_RD, F_CAP, F_PUSH} fstate_t;

    fstate_t              state_reg;
    logic [KCFG_W-1:0]    k_reg;
    logic [COLS_W-1:0]    cols_reg;
    logic [ROWS_W-1:0]    rows_reg;
    logic [COLW-1:0]      col_reg;
    logic [ROWS_W-1:0]    row_reg;
    logic [KW-1:0]        rd_r_reg;
    logic                 mode_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [COEF_IN_W-1:0] val_reg;
    logic [PIX_W-1:0]     pix_reg;
    logic [PIX_W-1:0]     colbuf_reg [MAX_KERNEL];

    logic [PIX_W-1:0]     ls_mem [LS_DEPTH];
    logic [PIX_W-1:0]     ls_q;
    logic                 ls_re, ls_we;
    logic [LS_AW-1:0]     ls_raddr, ls_waddr;
    logic [PIX_W-1:0]     ls_wdata;

    logic [KW-1:0]        keff;
    logic [COLS_W-1:0]    cols_eff;
    logic [ROWS_W-1:0]    rows_eff;
    logic                 cfg_hit;
    logic                 col_end, row_end;

    function automatic logic [LS_AW-1:0] ls_addr(input logic [KW-1:0] r,
                                                 input logic [COLW-1:0] c);
        ls_addr = (LS_AW'(r) << COLW) | LS_AW'(c);
    endfunction

    always_comb begin
        if (k_reg == '0) begin
            keff = KW'(1);
        end else if (int'(k_reg) > MAX_KERNEL) begin
            keff = KW'(MAX_KERNEL);
        end else begin
            keff = KW'(k_reg);
        end
        if (cols_reg == '0) begin
            cols_eff = COLS_W'(1);
        end else if (int'(cols_reg) > MAX_COLS) begin
            cols_eff = COLS_W'(MAX_COLS);
        end else begin
            cols_eff = cols_reg;
        end
        rows_eff = (rows_reg == '0) ? ROWS_W'(1) : rows_reg;
    end

    assign cfg_hit = cfg_valid && (cfg_index == CFG_KERNEL || cfg_index == CFG_COLS
                                   || cfg_index == CFG_ROWS);
    assign ctl.k       = keff;
    assign ctl.refresh = cfg_hit;

    assign s_ready = (state_reg == F_IDLE);
    assign q_push  = (state_reg == F_PUSH) && !q_full;

    assign col_end = (COLS_W'(col_reg) + COLS_W'(1)) == cols_eff;
    assign row_end = ((ROWS_W+1)'(row_reg) + (ROWS_W+1)'(1)) == (ROWS_W+1)'(rows_eff);

    always_comb begin
        q_item.is_coef = !mode_reg;
        q_item.idx     = idx_reg;
        q_item.val     = val_reg[COEF_BITS-1:0];
        for (int r = 0; r < MAX_KERNEL; r++) begin
            q_item.column[r] = (KW'(r) == keff - KW'(1)) ? pix_reg : colbuf_reg[r];
        end
        q_item.emit = (ROWS_W'(row_reg) >= ROWS_W'(keff - KW'(1)))
                   && (COLW'(col_reg) >= COLW'(keff - KW'(1)));
        q_item.last = row_end && col_end;
    end

    // line store port control
    always_comb begin
        ls_re    = (state_reg == F_RD);
        ls_raddr = ls_addr(rd_r_reg, col_reg);
        ls_we    = 1'b0;
        ls_waddr = ls_addr(rd_r_reg - KW'(1), col_reg);
        ls_wdata = ls_q;
        if (state_reg == F_CAP && rd_r_reg != '0) begin
            ls_we = 1'b1;
        end else if (q_push && mode_reg && keff >= KW'(2)) begin
            ls_we    = 1'b1;
            ls_waddr = ls_addr(keff - KW'(2), col_reg);
            ls_wdata = pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ls_we) begin
            ls_mem[ls_waddr] <= ls_wdata;
        end
        if (ls_re) begin
            ls_q <= ls_mem[ls_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            k_reg     <= KCFG_W'(3);
            cols_reg  <= COLS_W'(1024);
            rows_reg  <= ROWS_W'(768);
            col_reg   <= '0;
            row_reg   <= '0;
            rd_r_reg  <= '0;
        end else begin
            if (cfg_hit) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_KERNEL: k_reg    <= cfg_data[KCFG_W-1:0];
                    CFG_COLS:   cols_reg <= cfg_data[COLS_W-1:0];
                    CFG_ROWS:   rows_reg <= cfg_data[ROWS_W-1:0];
                    default:    k_reg    <= k_reg;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        mode_reg <= s_mode;
                        idx_reg  <= s_coef_index;
                        val_reg  <= s_coef_value;
                        pix_reg  <= {s_pixel_ch2, s_pixel_ch1, s_pixel_ch0};
                        rd_r_reg <= '0;
                        state_reg <= (s_mode && keff >= KW'(2)) ? F_RD : F_PUSH;
                    end
                end
                F_RD: state_reg <= F_CAP;
                F_CAP: begin
                    colbuf_reg[rd_r_reg] <= ls_q;
                    if (rd_r_reg == keff - KW'(2)) begin
                        state_reg <= F_PUSH;
                    end else begin
                        rd_r_reg  <= rd_r_reg + KW'(1);
                        state_reg <= F_RD;
                    end
                end
                F_PUSH: begin
                    if (!q_full) begin
                        state_reg <= F_IDLE;
                        if (!mode_reg) begin
                            col_reg <= '0;
                            row_reg <= '0;
                        end else if (col_end) begin
                            col_reg <= '0;
                            row_reg <= row_end ? '0 : row_reg + ROWS_W'(1);
                        end else begin
                            col_reg <= col_reg + COLW'(1);
                        end
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/nc2d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nc2d_queue
// Short FIFO of work items between the front and the back.
// ----------------------------------------------------------------------------
module nc2d_queue import nc2d_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output q_item_t pop_item,
    output logic    empty
);

    localparam int PW = $clog2(Q_DEPTH);

    q_item_t          mem_reg [Q_DEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [PW:0]      cnt_reg;

    assign full     = (cnt_reg == (PW+1)'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == PW'(Q_DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            end
            if (pop) begin
                rp_reg <= (rp_reg == PW'(Q_DEPTH - 1)) ? '0 : rp_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

### rtl/core/nc2d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nc2d_back
// Holds coefficients, weight sum and window; runs the multiply-accumulate
// over the window, the per-channel divide and the output register.
// ----------------------------------------------------------------------------
module nc2d_back import nc2d_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  ctl_t       ctl,
    input  logic       q_empty,
    input  q_item_t    q_item,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_ch0,
    output logic [7:0] m_out_ch1,
    output logic [7:0] m_out_ch2,
    output logic       m_last_of_image,
    output logic       m_zero_norm
);

    typedef enum logic [2:0] {B_IDLE, B_SUM, B_WCOL, B_MAC, B_DIV, B_OUT} bstate_t;

    localparam int DC_W = $clog2(ACC_W + 1);

    bstate_t              state_reg;
    q_item_t              cur_reg;
    logic [SUM_W-1:0]     wsum_reg;
    logic [SUM_W-1:0]     sacc_reg;
    logic [CNT_W-1:0]     iss_reg;
    logic                 v1_reg, v2_reg, idone_reg;
    logic [KW-1:0]        wr_r_reg, mr_reg, mc_reg;
    logic [SLOT_W-1:0]    wp_reg, mslot_reg;
    logic [TAP_W-1:0]     mci_reg;
    logic [PROD_W-1:0]    prod_reg [3];
    logic [ACC_W-1:0]     acc_reg [3];
    logic [SUM_W-1:0]     rem_reg [3];
    logic [DC_W-1:0]      dcnt_reg;
    logic                 zn_reg;

    logic [COEF_BITS-1:0] tbl_mem [TAPS];
    logic [TAPS-1:0]      tvalid_reg;
    logic [COEF_BITS-1:0] tbl_q;
    logic                 tbl_vq;
    logic                 t_re, t_we;
    logic [TAP_W-1:0]     t_raddr;
    logic [COEF_BITS-1:0] coef_rd;

    logic [PIX_W-1:0]     win_mem [2**WIN_AW];
    logic [PIX_W-1:0]     win_q;
    logic                 w_re, w_we;

    logic [CNT_W-1:0]     ntaps;
    logic [SLOT_W:0]      s0_tmp;
    logic [SUM_W:0]       trial [3];
    logic                 qbit [3];

    logic                 m_valid_reg, m_last_reg, m_zn_reg;
    logic [7:0]           m_ch_reg [3];

    assign ntaps   = CNT_W'(ctl.k) * CNT_W'(ctl.k);
    assign coef_rd = tbl_vq ? tbl_q : '0;
    assign q_pop   = (state_reg == B_IDLE) && !q_empty && !ctl.refresh;

    assign t_we    = q_pop && q_item.is_coef && (int'(q_item.idx) < TAPS);
    assign t_re    = (state_reg == B_SUM && iss_reg < ntaps)
                  || (state_reg == B_MAC && !idone_reg);
    assign t_raddr = (state_reg == B_SUM) ? iss_reg[TAP_W-1:0] : mci_reg;
    assign w_we    = (state_reg == B_WCOL);
    assign w_re    = (state_reg == B_MAC && !idone_reg);

    always_ff @(posedge aclk) begin
        if (t_we) begin
            tbl_mem[q_item.idx[TAP_W-1:0]] <= q_item.val;
        end
        if (t_re) begin
            tbl_q  <= tbl_mem[t_raddr];
            tbl_vq <= tvalid_reg[t_raddr];
        end
        if (w_we) begin
            win_mem[{wp_reg, wr_r_reg}] <= cur_reg.column[wr_r_reg];
        end
        if (w_re) begin
            win_q <= win_mem[{mslot_reg, mr_reg}];
        end
    end

    // oldest window column sits k-1 slots behind the newest
    assign s0_tmp = (SLOT_W+1)'(wp_reg) + (SLOT_W+1)'(MAX_KERNEL)
                  - (SLOT_W+1)'(ctl.k - KW'(1));

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            trial[ch] = {rem_reg[ch], acc_reg[ch][ACC_W-1]};
            qbit[ch]  = trial[ch] >= {1'b0, wsum_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            wsum_reg    <= '0;
            tvalid_reg  <= '0;
            wp_reg      <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (t_we) begin
                tvalid_reg[q_item.idx[TAP_W-1:0]] <= 1'b1;
            end
            unique case (state_reg)
                B_IDLE: begin
                    iss_reg  <= '0;
                    v1_reg   <= 1'b0;
                    sacc_reg <= '0;
                    wr_r_reg <= '0;
                    if (ctl.refresh) begin
                        state_reg <= B_SUM;
                    end else if (!q_empty) begin
                        cur_reg   <= q_item;
                        state_reg <= q_item.is_coef ? B_SUM : B_WCOL;
                    end
                end
                B_SUM: begin
                    v1_reg <= iss_reg < ntaps;
                    if (iss_reg < ntaps) begin
                        iss_reg <= iss_reg + CNT_W'(1);
                    end
                    if (v1_reg) begin
                        sacc_reg <= sacc_reg + SUM_W'(coef_rd);
                    end else if (iss_reg == ntaps) begin
                        wsum_reg  <= sacc_reg;
                        state_reg <= B_IDLE;
                    end
                end
                B_WCOL: begin
                    if (wr_r_reg == ctl.k - KW'(1)) begin
                        wp_reg <= (wp_reg == SLOT_W'(MAX_KERNEL - 1))
                                ? '0 : wp_reg + SLOT_W'(1);
                        mslot_reg <= (s0_tmp >= (SLOT_W+1)'(MAX_KERNEL))
                                   ? SLOT_W'(s0_tmp - (SLOT_W+1)'(MAX_KERNEL))
                                   : SLOT_W'(s0_tmp);
                        mr_reg    <= '0;
                        mc_reg    <= '0;
                        mci_reg   <= '0;
                        idone_reg <= 1'b0;
                        v1_reg    <= 1'b0;
                        v2_reg    <= 1'b0;
                        for (int ch = 0; ch < 3; ch++) begin
                            acc_reg[ch] <= '0;
                        end
                        state_reg <= cur_reg.emit ? B_MAC : B_IDLE;
                    end else begin
                        wr_r_reg <= wr_r_reg + KW'(1);
                    end
                end
                B_MAC: begin
                    v1_reg <= !idone_reg;
                    v2_reg <= v1_reg;
                    if (!idone_reg) begin
                        if (mr_reg == ctl.k - KW'(1)) begin
                            mr_reg    <= '0;
                            mc_reg    <= mc_reg + KW'(1);
                            mci_reg   <= TAP_W'(mc_reg) + TAP_W'(1);
                            mslot_reg <= (mslot_reg == SLOT_W'(MAX_KERNEL - 1))
                                       ? '0 : mslot_reg + SLOT_W'(1);
                            if (mc_reg == ctl.k - KW'(1)) begin
                                idone_reg <= 1'b1;
                            end
                        end else begin
                            mr_reg  <= mr_reg + KW'(1);
                            mci_reg <= mci_reg + TAP_W'(ctl.k);
                        end
                    end
                    for (int ch = 0; ch < 3; ch++) begin
                        if (v1_reg) begin
                            prod_reg[ch] <= PROD_W'(win_q[8*ch +: 8]) * PROD_W'(coef_rd);
                        end
                        if (v2_reg) begin
                            acc_reg[ch] <= acc_reg[ch] + ACC_W'(prod_reg[ch]);
                        end
                    end
                    if (idone_reg && !v1_reg && !v2_reg) begin
                        for (int ch = 0; ch < 3; ch++) begin
                            rem_reg[ch] <= '0;
                        end
                        dcnt_reg  <= '0;
                        zn_reg    <= (wsum_reg == '0);
                        state_reg <= (wsum_reg == '0) ? B_OUT : B_DIV;
                    end
                end
                B_DIV: begin
                    // one restoring step per cycle, quotient shifts into acc
                    for (int ch = 0; ch < 3; ch++) begin
                        rem_reg[ch] <= qbit[ch] ? SUM_W'(trial[ch] - {1'b0, wsum_reg})
                                                : SUM_W'(trial[ch]);
                        acc_reg[ch] <= {acc_reg[ch][ACC_W-2:0], qbit[ch]};
                    end
                    dcnt_reg <= dcnt_reg + DC_W'(1);
                    if (dcnt_reg == DC_W'(ACC_W - 1)) begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_last_reg  <= cur_reg.last;
                        m_zn_reg    <= zn_reg;
                        for (int ch = 0; ch < 3; ch++) begin
                            m_ch_reg[ch] <= zn_reg ? 8'd0 : acc_reg[ch][7:0];
                        end
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_ch0       = m_ch_reg[0];
    assign m_out_ch1       = m_ch_reg[1];
    assign m_out_ch2       = m_ch_reg[2];
    assign m_last_of_image = m_last_reg;
    assign m_zero_norm     = m_zn_reg;

endmodule

### rtl/core/normalized_2d_convolution.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_2d_convolution
// KxK normalized correlation over a raster stream of 3-channel pixels.
// ----------------------------------------------------------------------------
// Input channel s_*: one word per item. s_mode=0 loads kernel entry
// s_coef_index with s_coef_value and restarts the frame; s_mode=1 carries a
// pixel. Result channel m_*: one word per full KxK window, raster order,
// with m_last_of_image on the final window and m_zero_norm when the kernel
// weights sum to zero (channel outputs then 0). Configuration channel
// cfg_*: kernel side, image columns, image rows at index 0, 1, 2; written
// while idle.
// Per pixel, the front takes the word, reads and ages the line store column
// row by row, each row read and then captured, and pushes to the queue; it
// accepts no new word until the queue has taken the last one. The back takes
// the word from the queue, writes the window column, runs the
// multiply-accumulate loop over the window memory and the per-channel
// restoring divide (skipped when the weights sum to zero), then loads the
// output register; a pixel that closes no window ends after the column
// write. A coefficient load or configuration write makes the back re-sum the
// weights. The two-entry queue lets the front prepare the next column while
// the back works.
// Reset clears position, coefficients, weight sum and all valid flags; the
// line store is not cleared. A stalled m_ready holds the result in the
// output register while the block goes on accepting words until the queue
// fills.
// ----------------------------------------------------------------------------
module normalized_2d_convolution import nc2d_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [IDX_W-1:0]     s_coef_index,
    input  logic [COEF_IN_W-1:0] s_coef_value,
    input  logic [7:0]           s_pixel_ch0,
    input  logic [7:0]           s_pixel_ch1,
    input  logic [7:0]           s_pixel_ch2,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_ch0,
    output logic [7:0]           m_out_ch1,
    output logic [7:0]           m_out_ch2,
    output logic                 m_last_of_image,
    output logic                 m_zero_norm
);

    ctl_t    ctl;
    logic    q_push, q_full, q_pop, q_empty;
    q_item_t q_in, q_out;

    assign cfg_ready = 1'b1;

    nc2d_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_coef_index (s_coef_index),
        .s_coef_value (s_coef_value),
        .s_pixel_ch0  (s_pixel_ch0),
        .s_pixel_ch1  (s_pixel_ch1),
        .s_pixel_ch2  (s_pixel_ch2),
        .ctl          (ctl),
        .q_push       (q_push),
        .q_item       (q_in),
        .q_full       (q_full)
    );

    nc2d_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out),
        .empty     (q_empty)
    );

    nc2d_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (ctl),
        .q_empty         (q_empty),
        .q_item          (q_out),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_ch0       (m_out_ch0),
        .m_out_ch1       (m_out_ch1),
        .m_out_ch2       (m_out_ch2),
        .m_last_of_image (m_last_of_image),
        .m_zero_norm     (m_zero_norm)
    );

endmodule

### rtl/core/nc2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nc2d_checker
// Port-level checks of the normalized 2D convolution block.
// ----------------------------------------------------------------------------
module nc2d_checker import nc2d_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [7:0]           m_out_ch0,
    input logic [7:0]           m_out_ch1,
    input logic [7:0]           m_out_ch2,
    input logic                 m_last_of_image,
    input logic                 m_zero_norm
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_ch0) && $stable(m_out_ch1)
            && $stable(m_out_ch2) && $stable(m_last_of_image) && $stable(m_zero_norm))
        else $error("result word changed while stalled");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_norm |-> m_out_ch0 == 8'd0 && m_out_ch1 == 8'd0
            && m_out_ch2 == 8'd0)
        else $error("zero weight sum with nonzero output");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

endmodule

bind normalized_2d_convolution nc2d_checker u_nc2d_checker (.*);
